// ===== hdl/bpps_pkg.sv =====
// Shared types and constants for the brew pump profile sequencer.
// No dependencies; imported by every module in hdl/.
package bpps_pkg;

    localparam int unsigned DUTY_W     = 9;
    localparam int unsigned TICK_W     = 11;
    localparam int unsigned DIV_W      = 8;
    localparam int unsigned PULSE_W    = 4;
    localparam int unsigned SHOT_W     = 16;
    localparam int unsigned IDLE_W     = 14;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 32;

    localparam logic [DUTY_W-1:0]  DUTY_FULL   = 9'd256;
    localparam logic [DUTY_W-1:0]  DUTY_MIN    = 9'd26;
    localparam logic [DUTY_W:0]    RAMP_STEP   = 10'd16;
    localparam logic [DIV_W-1:0]   RAMP_DIV    = 8'd5;
    localparam logic [DIV_W-1:0]   PULL_DIV    = 8'd15;
    localparam logic [IDLE_W-1:0]  IDLE_CLEAR  = 14'd12500;
    localparam logic [IDLE_W-1:0]  IDLE_MAX    = 14'd16383;
    localparam logic [TICK_W-1:0]  PROG_MAX    = 11'd2047;
    localparam logic [SHOT_W-1:0]  SHOT_MAX    = 16'd65535;
    localparam logic [PULSE_W-1:0] PULSE_MAX   = 4'd15;
    localparam logic [PULSE_W-1:0] PULSE_SOLID = 4'd10;
    localparam logic [TICK_W:0]    ALARM_LEN   = 12'd5;
    localparam logic [TICK_W-1:0]  REWIND_SHORT = 11'd25;
    localparam logic [TICK_W-1:0]  REWIND_LONG  = 11'd250;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PREINFUSE_DUTY = 3'd0,
        CFG_PREINFUSE_END  = 3'd1,
        CFG_SOAK_END       = 3'd2,
        CFG_RAMP_END       = 3'd3,
        CFG_PULL_END       = 3'd4,
        CFG_FLOOR_START    = 3'd5,
        CFG_PUMP_STOP_AT   = 3'd6,
        CFG_ALARM_AT       = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [DUTY_W-1:0] preinfuse_duty;
        logic [TICK_W-1:0] preinfuse_end;
        logic [TICK_W-1:0] soak_end;
        logic [TICK_W-1:0] ramp_end;
        logic [TICK_W-1:0] pull_end;
        logic [TICK_W-1:0] floor_start;
        logic [TICK_W-1:0] pump_stop_at;
        logic [TICK_W-1:0] alarm_at;
    } t_cfg;

    typedef struct packed {
        logic tick;
        logic water_on;
        logic steam_on;
        logic brew_on;
        logic power_on;
    } t_item;

    typedef struct packed {
        logic              pump_timer_run;
        logic [SHOT_W-1:0] shot_time;
        logic              piezo;
        logic [DUTY_W-1:0] pump_duty;
    } t_result;

endpackage

// ===== hdl/bpps_cfg_regs.sv =====
// Configuration register bank for the brew pump profile sequencer.
// Depends on bpps_pkg.
module bpps_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_we,
    input  logic [bpps_pkg::CFG_IDX_W-1:0]  i_idx,
    input  logic [bpps_pkg::CFG_DATA_W-1:0] i_data,
    output bpps_pkg::t_cfg                  o_cfg
);
    import bpps_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preinfuse_duty <= 9'd40;
            r_cfg.preinfuse_end  <= 11'd20;
            r_cfg.soak_end       <= 11'd40;
            r_cfg.ramp_end       <= 11'd65;
            r_cfg.pull_end       <= 11'd801;
            r_cfg.floor_start    <= 11'd360;
            r_cfg.pump_stop_at   <= 11'd600;
            r_cfg.alarm_at       <= 11'd851;
        end else if (i_we) begin
            unique case (t_cfg_idx'(i_idx))
                CFG_PREINFUSE_DUTY: r_cfg.preinfuse_duty <= i_data[DUTY_W-1:0];
                CFG_PREINFUSE_END:  r_cfg.preinfuse_end  <= i_data;
                CFG_SOAK_END:       r_cfg.soak_end       <= i_data;
                CFG_RAMP_END:       r_cfg.ramp_end       <= i_data;
                CFG_PULL_END:       r_cfg.pull_end       <= i_data;
                CFG_FLOOR_START:    r_cfg.floor_start    <= i_data;
                CFG_PUMP_STOP_AT:   r_cfg.pump_stop_at   <= i_data;
                CFG_ALARM_AT:       r_cfg.alarm_at       <= i_data;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/bpps_core.sv =====
// Per-pass state update: phase counter, pump duty, alarm and shot timer.
// Depends on bpps_pkg.
module bpps_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  bpps_pkg::t_item   i_item,
    input  bpps_pkg::t_cfg    i_cfg,
    output bpps_pkg::t_result o_result
);
    import bpps_pkg::*;

    logic [TICK_W-1:0]  r_progress, n_progress;
    logic [DIV_W-1:0]   r_div,      n_div;
    logic [DUTY_W-1:0]  r_duty,     n_duty;
    logic [PULSE_W-1:0] r_pulses,   n_pulses;
    logic               r_buzzer,   n_buzzer;
    logic [SHOT_W-1:0]  r_shot,     n_shot;
    logic [IDLE_W-1:0]  r_idle,     n_idle;
    logic               r_run,      n_run;

    always_comb begin
        logic [DUTY_W-1:0] pre_duty;
        logic [DUTY_W:0]   ramp_sum;
        logic [TICK_W-1:0] p;

        pre_duty = (i_cfg.preinfuse_duty > DUTY_FULL) ? DUTY_FULL : i_cfg.preinfuse_duty;
        p        = r_progress;
        ramp_sum = '0;

        n_progress = r_progress;
        n_div      = r_div;
        n_duty     = r_duty;
        n_pulses   = r_pulses;
        n_buzzer   = r_buzzer;
        n_shot     = r_shot;
        n_idle     = r_idle;
        n_run      = r_run;

        if (i_item.power_on) begin
            if (i_item.brew_on) begin
                n_idle = '0;
                n_run  = 1'b1;
                if (p <= i_cfg.preinfuse_end)
                    n_duty = pre_duty;
                if (p > i_cfg.preinfuse_end && p <= i_cfg.soak_end)
                    n_duty = '0;
                if (p > i_cfg.soak_end && p <= i_cfg.ramp_end && n_duty <= DUTY_FULL) begin
                    n_div = n_div + 1'b1;
                    if (n_div > RAMP_DIV) begin
                        if (n_duty < DUTY_FULL) begin
                            ramp_sum = {1'b0, n_duty} + RAMP_STEP;
                            n_duty = (ramp_sum > {1'b0, DUTY_FULL}) ? DUTY_FULL
                                                                     : ramp_sum[DUTY_W-1:0];
                        end
                        n_div = '0;
                    end
                end
                if (p > i_cfg.ramp_end && p <= i_cfg.pull_end && n_duty >= DUTY_MIN) begin
                    n_div = n_div + 1'b1;
                    if (n_div > PULL_DIV) begin
                        n_duty = n_duty - 1'b1;
                        n_div  = '0;
                    end
                end
                if (p > i_cfg.floor_start)
                    n_duty = DUTY_MIN;
                if (p > i_cfg.pump_stop_at)
                    n_duty = '0;

                if (p >= i_cfg.alarm_at)
                    n_buzzer = 1'b1;
                if ({1'b0, p} >= {1'b0, i_cfg.alarm_at} + ALARM_LEN) begin
                    n_buzzer   = 1'b0;
                    n_progress = (i_cfg.alarm_at > REWIND_SHORT)
                               ? i_cfg.alarm_at - REWIND_SHORT : '0;
                    if (n_pulses < PULSE_MAX)
                        n_pulses = n_pulses + 1'b1;
                end
                if (n_pulses >= PULSE_SOLID) begin
                    n_buzzer   = 1'b1;
                    n_progress = (i_cfg.alarm_at > REWIND_LONG)
                               ? i_cfg.alarm_at - REWIND_LONG : '0;
                    n_pulses   = PULSE_SOLID;
                end

                if (i_item.tick) begin
                    if (n_progress < PROG_MAX)
                        n_progress = n_progress + 1'b1;
                    if (n_progress > i_cfg.soak_end && n_shot < SHOT_MAX)
                        n_shot = n_shot + 1'b1;
                end
            end else begin
                n_buzzer   = 1'b0;
                n_pulses   = '0;
                n_run      = 1'b0;
                n_progress = '0;
                n_duty     = '0;
                if (n_idle < IDLE_MAX)
                    n_idle = n_idle + 1'b1;
                if (n_idle >= IDLE_CLEAR)
                    n_shot = '0;
            end
            if (i_item.water_on)
                n_duty = DUTY_FULL;
        end else begin
            n_shot   = '0;
            n_duty   = '0;
            n_buzzer = 1'b0;
        end

        if (!i_item.brew_on && !i_item.steam_on && !i_item.water_on)
            n_duty = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_progress <= '0;
            r_div      <= '0;
            r_duty     <= '0;
            r_pulses   <= '0;
            r_buzzer   <= 1'b0;
            r_shot     <= '0;
            r_idle     <= '0;
            r_run      <= 1'b0;
        end else if (i_step) begin
            r_progress <= n_progress;
            r_div      <= n_div;
            r_duty     <= n_duty;
            r_pulses   <= n_pulses;
            r_buzzer   <= n_buzzer;
            r_shot     <= n_shot;
            r_idle     <= n_idle;
            r_run      <= n_run;
        end
    end

    assign o_result.pump_duty      = n_duty;
    assign o_result.piezo          = n_buzzer;
    assign o_result.shot_time      = n_shot;
    assign o_result.pump_timer_run = n_run;

endmodule

// ===== hdl/brew_pump_profile_sequencer.sv =====
// Top level of the brew pump profile sequencer: stream ports, input and result registers.
// Depends on bpps_pkg, bpps_cfg_regs and bpps_core.
//
// Each input beat is one control-loop pass and yields exactly one result beat.
// A beat is held in an input register, the pass is computed combinationally by the
// core and is written to the result register when that register is free or drained.
// One beat per cycle is sustained while the downstream side keeps tready high: the
// state update of one pass feeding the next is a registered loop in the core, and a
// waiting result stalls the input only once both registers are full. Configuration
// writes take effect at once and are to be made only while no beat is in flight.
module brew_pump_profile_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bpps_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bpps_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // power_on, brew_on, steam_on, water_on, tick, zero pad
    input  logic [bpps_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // pump_duty[8:0], piezo, shot_time[15:0], pump_timer_run, zero pad
    output logic [bpps_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import bpps_pkg::*;

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_result r_out, core_result;
    logic    r_out_valid;
    logic    out_free;
    logic    step;

    bpps_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    bpps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_item.power_on <= i_s_axis_tdata[0];
            r_item.brew_on  <= i_s_axis_tdata[1];
            r_item.steam_on <= i_s_axis_tdata[2];
            r_item.water_on <= i_s_axis_tdata[3];
            r_item.tick     <= i_s_axis_tdata[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, r_out};

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[8:0] <= DUTY_FULL)
        else $error("pump duty above full scale");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input accepted while both stages are full");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_m_axis_tvalid)
        else $error("computed pass did not reach the result register");

endmodule
